[rtl/sfd_pkg.sv]
// Shared widths, register map and reset values for the serial frame deframer.
package sfd_pkg;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 6;
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        REG_HEADER    = 2'd0,
        REG_FOOTER_F1 = 2'd1,
        REG_FOOTER_F2 = 2'd2,
        REG_FOOTER_F3 = 2'd3
    } t_reg_idx;

    localparam logic [BYTE_W-1:0] HEADER_RST    = 8'hAA;
    localparam logic [BYTE_W-1:0] FOOTER_F1_RST = 8'h55;
    localparam logic [BYTE_W-1:0] FOOTER_F2_RST = 8'h44;
    localparam logic [BYTE_W-1:0] FOOTER_F3_RST = 8'h33;

endpackage

[rtl/sfd_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module sfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/serial_frame_deframer_reinject.sv]
// Header/footer byte deframer. A received byte is normally taken and written straight
// into the payload RAM. When a broken footer puts its matched bytes back as data,
// the extra bytes go through the single RAM write port one per cycle, and no input
// transfer is taken until they are all written. A complete footer starts the drain:
// each payload byte goes through a registered RAM read (S_RD) and then a load of the
// output register (S_LD), which waits while the output is stalled; an empty frame still
// gives one zero result, and no input transfer is taken while the drain runs. There is no
// clearing pass after reset: only entries already written in the current frame are output.
module serial_frame_deframer_reinject #(
    parameter int BUFFER_BYTES = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // received byte channel
    input  logic                                i_rx_valid,
    output logic                                o_rx_stall,
    input  logic [sfd_pkg::BYTE_W-1:0]          i_rx_byte,
    // result channel
    output logic                                o_res_valid,
    input  logic                                i_res_stall,
    output logic [sfd_pkg::BYTE_W-1:0]          o_payload_byte,
    output logic [sfd_pkg::LEN_W-1:0]           o_frame_length,
    output logic                                o_last_of_frame,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [sfd_pkg::ADDR_W-1:0]          paddr,
    input  logic [sfd_pkg::DATA_W-1:0]          pwdata,
    output logic [sfd_pkg::DATA_W-1:0]          prdata,
    output logic                                pready
);

    localparam int AW = $clog2(BUFFER_BYTES);
    localparam int LW = sfd_pkg::LEN_W;
    localparam int BW = sfd_pkg::BYTE_W;
    localparam logic [LW:0] LIM1 = (LW+1)'(BUFFER_BYTES - 1);
    localparam logic [LW:0] LIM2 = (LW+1)'(BUFFER_BYTES - 2);
    localparam logic [LW:0] LIM3 = (LW+1)'(BUFFER_BYTES - 3);

    typedef enum logic [1:0] {
        PH_WAIT_HEADER,
        PH_IN_DATA,
        PH_AFTER_F1,
        PH_AFTER_F2
    } t_phase;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PUT,
        S_RD,
        S_LD
    } t_state;

    // configuration registers
    logic [BW-1:0] r_header, r_foot1, r_foot2, r_foot3;

    t_state         r_state, n_state;
    t_phase         r_phase, n_phase;
    logic [LW-1:0]  r_count, n_count;
    logic [LW-1:0]  r_total, n_total;
    logic [LW-1:0]  r_idx, n_idx;
    logic [1:0][BW-1:0] r_q, n_q;
    logic [1:0]     r_wn, n_wn;
    logic           r_ovalid, n_ovalid;
    logic [BW-1:0]  r_obyte, n_obyte;
    logic [LW-1:0]  r_olen, n_olen;
    logic           r_olast, n_olast;

    logic           we;
    logic [BW-1:0]  wdata;
    logic           re;
    logic [BW-1:0]  rdata;
    logic           rx_take;
    logic           out_free;
    logic           is_last;
    logic [LW:0]    cnt_ext;
    logic           cfg_wr;
    sfd_pkg::t_reg_idx cfg_idx;

    sfd_ram #(
        .WIDTH (BW),
        .DEPTH (BUFFER_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (rdata)
    );

    assign o_rx_stall = (r_state != S_IDLE);
    assign rx_take    = i_rx_valid && !o_rx_stall;
    assign out_free   = !r_ovalid || !i_res_stall;
    assign cnt_ext    = {1'b0, r_count};
    assign is_last    = (r_total == '0) || (({1'b0, r_idx} + 1'b1) == {1'b0, r_total});
    assign re         = (r_state == S_RD);

    always_comb begin
        n_state  = r_state;
        n_phase  = r_phase;
        n_count  = r_count;
        n_total  = r_total;
        n_idx    = r_idx;
        n_q      = r_q;
        n_wn     = r_wn;
        n_ovalid = r_ovalid && i_res_stall;
        n_obyte  = r_obyte;
        n_olen   = r_olen;
        n_olast  = r_olast;
        we       = 1'b0;
        wdata    = i_rx_byte;

        case (r_state)
            S_IDLE: begin
                if (rx_take) begin
                    case (r_phase)
                        PH_WAIT_HEADER: begin
                            if (i_rx_byte == r_header) begin
                                n_phase = PH_IN_DATA;
                                n_count = '0;
                            end
                        end
                        PH_IN_DATA: begin
                            if (i_rx_byte == r_foot1) begin
                                n_phase = PH_AFTER_F1;
                            end else if (cnt_ext < LIM1) begin
                                we      = 1'b1;
                                n_count = r_count + 1'b1;
                            end else begin
                                n_phase = PH_WAIT_HEADER;
                                n_count = '0;
                            end
                        end
                        PH_AFTER_F1: begin
                            if (i_rx_byte == r_foot2) begin
                                n_phase = PH_AFTER_F2;
                            end else if (cnt_ext < LIM2) begin
                                // Put the first footer byte back now, the breaking byte next.
                                we      = 1'b1;
                                wdata   = r_foot1;
                                n_count = r_count + 1'b1;
                                n_q[0]  = i_rx_byte;
                                n_wn    = 2'd1;
                                n_phase = PH_IN_DATA;
                                n_state = S_PUT;
                            end else begin
                                n_phase = PH_WAIT_HEADER;
                                n_count = '0;
                            end
                        end
                        default: begin
                            if (i_rx_byte == r_foot3) begin
                                n_total = r_count;
                                n_idx   = '0;
                                n_phase = PH_WAIT_HEADER;
                                n_count = '0;
                                n_state = S_RD;
                            end else if (cnt_ext < LIM3) begin
                                we      = 1'b1;
                                wdata   = r_foot1;
                                n_count = r_count + 1'b1;
                                n_q[0]  = r_foot2;
                                n_q[1]  = i_rx_byte;
                                n_wn    = 2'd2;
                                n_phase = PH_IN_DATA;
                                n_state = S_PUT;
                            end else begin
                                n_phase = PH_WAIT_HEADER;
                                n_count = '0;
                            end
                        end
                    endcase
                end
            end
            S_PUT: begin
                we      = 1'b1;
                wdata   = r_q[0];
                n_count = r_count + 1'b1;
                n_q[0]  = r_q[1];
                n_wn    = r_wn - 1'b1;
                if (r_wn == 2'd1) begin
                    n_state = S_IDLE;
                end
            end
            S_RD: begin
                n_state = S_LD;
            end
            S_LD: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_obyte  = (r_total == '0) ? '0 : rdata;
                    n_olen   = r_total;
                    n_olast  = is_last;
                    if (is_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = sfd_pkg::t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_phase  <= PH_WAIT_HEADER;
            r_count  <= '0;
            r_ovalid <= 1'b0;
            r_header <= sfd_pkg::HEADER_RST;
            r_foot1  <= sfd_pkg::FOOTER_F1_RST;
            r_foot2  <= sfd_pkg::FOOTER_F2_RST;
            r_foot3  <= sfd_pkg::FOOTER_F3_RST;
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
            if (cfg_wr) begin
                case (cfg_idx)
                    sfd_pkg::REG_HEADER:    r_header <= pwdata[BW-1:0];
                    sfd_pkg::REG_FOOTER_F1: r_foot1  <= pwdata[BW-1:0];
                    sfd_pkg::REG_FOOTER_F2: r_foot2  <= pwdata[BW-1:0];
                    sfd_pkg::REG_FOOTER_F3: r_foot3  <= pwdata[BW-1:0];
                    default: ;
                endcase
            end
        end
        r_total <= n_total;
        r_idx   <= n_idx;
        r_q     <= n_q;
        r_wn    <= n_wn;
        r_obyte <= n_obyte;
        r_olen  <= n_olen;
        r_olast <= n_olast;
    end

    always_comb begin
        case (cfg_idx)
            sfd_pkg::REG_HEADER:    prdata = {{(sfd_pkg::DATA_W-BW){1'b0}}, r_header};
            sfd_pkg::REG_FOOTER_F1: prdata = {{(sfd_pkg::DATA_W-BW){1'b0}}, r_foot1};
            sfd_pkg::REG_FOOTER_F2: prdata = {{(sfd_pkg::DATA_W-BW){1'b0}}, r_foot2};
            sfd_pkg::REG_FOOTER_F3: prdata = {{(sfd_pkg::DATA_W-BW){1'b0}}, r_foot3};
            default:                prdata = '0;
        endcase
    end

    assign pready          = 1'b1;
    assign o_res_valid     = r_ovalid;
    assign o_payload_byte  = r_obyte;
    assign o_frame_length  = r_olen;
    assign o_last_of_frame = r_olast;

endmodule

[rtl/sfd_checker.sv]
// Port-level checker for the serial frame deframer, bound to the top level.
module sfd_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_res_valid,
    input logic                       i_res_stall,
    input logic [sfd_pkg::BYTE_W-1:0] o_payload_byte,
    input logic [sfd_pkg::LEN_W-1:0]  o_frame_length,
    input logic                       o_last_of_frame
);

    // No result may be offered straight after reset.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res_valid)
        else $error("result offered after reset");

    // A stalled result transfer keeps its payload.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && i_res_stall |=>
            o_res_valid && $stable(o_payload_byte) && $stable(o_frame_length)
            && $stable(o_last_of_frame))
        else $error("stalled result changed");

    // An empty frame gives a single zero result marked last.
    a_empty_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_frame_length == '0 |-> o_last_of_frame && o_payload_byte == '0)
        else $error("malformed empty frame result");

    // Within a frame the length does not change from one result to the next.
    a_len_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !i_res_stall && !o_last_of_frame |=>
            !o_res_valid || o_frame_length == $past(o_frame_length))
        else $error("frame length changed inside a frame");

endmodule

bind serial_frame_deframer_reinject sfd_checker u_sfd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_res_valid     (o_res_valid),
    .i_res_stall     (i_res_stall),
    .o_payload_byte  (o_payload_byte),
    .o_frame_length  (o_frame_length),
    .o_last_of_frame (o_last_of_frame)
);
